### design/wsd_pkg.sv
// shared types and constants of the websocket frame deframer
// result word layout, push bundle between step logic and result queue
// no dependencies
package wsd_pkg;

  localparam int unsigned CFG_W     = 17;
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int unsigned Q_DEPTH   = 8;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = Q_PTR_W + 1;

  localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = 17'h10000;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [7:0] PONG_HDR0 = 8'h8A;

  typedef enum logic [1:0] {
    KIND_APP   = 2'd0,
    KIND_PONG  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_ERROR = 2'd3
  } wsd_kind_e;

  typedef struct packed {
    logic [7:0] out_byte;
    wsd_kind_e  kind;
    logic       last;
  } wsd_res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]       cnt;
    wsd_res_t [MAX_RES-1:0]     res;
  } wsd_push_t;

  function automatic wsd_res_t mk_res(logic [7:0] b, wsd_kind_e k, logic l);
    wsd_res_t r;
    r.out_byte = b;
    r.kind     = k;
    r.last     = l;
    return r;
  endfunction

endpackage

### design/websocket_frame_deframer.sv
// websocket frame deframer: header parse, length check, unmasking, pong reply
// a word is registered in the result queue before it shows on the master side
// throughput: one byte per cycle; a byte that ends a ping header yields up to
// four words, and the input stalls while the result queue holds more than four
// reset (async, active low): first header byte, max_payload 65536, queue empty
// depends on wsd_pkg and wsd_res_fifo
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_STOP = 3'd5;

  logic [2:0]             phase_q, phase_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   mask_en_q, mask_en_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   ovf_q, ovf_d;
  logic [3:0]             left_q, left_d;
  logic [31:0]            key_q, key_d;
  logic [LENGTH_BITS-1:0] idx_q, idx_d;
  logic [CFG_W-1:0]       max_payload_q;

  logic                   in_acc;
  logic                   cfg_wr;
  logic [7:0]             b;
  logic [6:0]             len7;
  logic [LENGTH_BITS+7:0] ext_wide;
  logic [31:0]            len32;
  logic [7:0]             key_byte;
  logic [7:0]             data;
  logic                   fin;
  logic                   do_len;
  logic                   do_begin;
  wsd_push_t              push;
  wsd_res_t               res;
  logic                   room;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = room;
  assign b        = s_axis_tdata;
  assign len7     = b[6:0];
  assign ext_wide = {len_q, b};

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(max_payload_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      max_payload_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    case (idx_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    mask_en_d = mask_en_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    left_d    = left_q;
    key_d     = key_q;
    idx_d     = idx_q;
    push      = '0;
    do_len    = 1'b0;
    do_begin  = 1'b0;
    data      = b ^ (mask_en_q ? key_byte : 8'd0);
    fin       = 1'b0;
    len32     = '0;

    if (in_acc) begin
      case (phase_q)
        PH_HDR0: begin
          opcode_d = b[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_en_d = b[7];
          ovf_d     = 1'b0;
          if (opcode_q == OP_CLOSE) begin
            phase_d     = PH_STOP;
            push.cnt    = RES_CNT_W'(1);
            push.res[0] = mk_res(8'd0, KIND_CLOSE, 1'b0);
          end else if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
            len_d   = '0;
            left_d  = (len7 == LEN_EXT16) ? 4'd2 : 4'd8;
            phase_d = PH_EXT;
          end else begin
            len_d  = LENGTH_BITS'(len7);
            do_len = 1'b1;
          end
        end
        PH_EXT: begin
          // bits shifted out above the length width mark the frame oversize
          ovf_d  = ovf_q | (|ext_wide[LENGTH_BITS+7:LENGTH_BITS]);
          len_d  = ext_wide[LENGTH_BITS-1:0];
          left_d = 4'(left_q - 4'd1);
          do_len = (left_d == 4'd0);
        end
        PH_MASK: begin
          key_d    = {key_q[23:0], b};
          left_d   = 4'(left_q - 4'd1);
          do_begin = (left_d == 4'd0);
        end
        PH_DATA: begin
          idx_d = LENGTH_BITS'(idx_q + 1'b1);
          fin   = (idx_d == len_q);
          if (opcode_q == OP_PING) begin
            push.cnt    = RES_CNT_W'(1);
            push.res[0] = mk_res(data, KIND_PONG, fin);
          end else if (opcode_q != OP_PONG) begin
            push.cnt    = RES_CNT_W'(1);
            push.res[0] = mk_res(data, KIND_APP, fin);
          end
          if (fin) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          phase_d = PH_STOP;
        end
      endcase
    end

    len32 = 32'(len_d);

    if (do_len) begin
      if (ovf_d || len32 > 32'(max_payload_q)) begin
        phase_d     = PH_STOP;
        push.cnt    = RES_CNT_W'(1);
        push.res[0] = mk_res(8'd0, KIND_ERROR, 1'b0);
      end else if (mask_en_d) begin
        key_d   = '0;
        left_d  = 4'd4;
        phase_d = PH_MASK;
      end else begin
        do_begin = 1'b1;
      end
    end

    if (do_begin) begin
      // ping: pong header goes out together with the end of the received header
      if (opcode_q == OP_PING) begin
        push.res[0] = mk_res(PONG_HDR0, KIND_PONG, 1'b0);
        if (len32 < 32'(LEN_EXT16)) begin
          push.cnt    = RES_CNT_W'(2);
          push.res[1] = mk_res(len32[7:0], KIND_PONG, len32 == 32'd0);
        end else begin
          push.cnt    = RES_CNT_W'(4);
          push.res[1] = mk_res(8'(LEN_EXT16), KIND_PONG, 1'b0);
          push.res[2] = mk_res(len32[15:8], KIND_PONG, 1'b0);
          push.res[3] = mk_res(len32[7:0], KIND_PONG, 1'b0);
        end
      end
      idx_d   = '0;
      phase_d = (len32 == 32'd0) ? PH_HDR0 : PH_DATA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      opcode_q  <= '0;
      mask_en_q <= 1'b0;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      left_q    <= '0;
      key_q     <= '0;
      idx_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      mask_en_q <= mask_en_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      left_q    <= left_d;
      key_q     <= key_d;
      idx_q     <= idx_d;
    end
  end

  wsd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = res.out_byte;
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STOP |=> phase_q == PH_STOP)
    else $error("left stopped state without reset");

  a_push_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt != '0 |-> in_acc)
    else $error("words pushed without an accepted byte");

  a_data_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> (len_q != '0 && idx_q < len_q))
    else $error("payload index out of frame");

endmodule

### design/wsd_res_fifo.sv
// result queue: takes up to four words per cycle, hands out one per cycle while ready_i is high
// depends on wsd_pkg
module wsd_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wsd_pkg::wsd_push_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output wsd_pkg::wsd_res_t  res_o
);
  import wsd_pkg::*;

  wsd_res_t [Q_DEPTH-1:0] mem_q;
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o & ready_i;
  assign res_o   = mem_q[rd_ptr_q];
  // room for the largest burst a single byte can cause
  assign room_o  = (count_q <= Q_CNT_W'(Q_DEPTH - MAX_RES));

  assign wr_ptr_d = Q_PTR_W'(wr_ptr_q + Q_PTR_W'(push_i.cnt));
  assign rd_ptr_d = Q_PTR_W'(rd_ptr_q + Q_PTR_W'(pop));
  assign count_d  = Q_CNT_W'(count_q + Q_CNT_W'(push_i.cnt) - Q_CNT_W'(pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CNT_W'(k) < push_i.cnt) begin
        mem_q[Q_PTR_W'(wr_ptr_q + Q_PTR_W'(k))] <= push_i.res[k];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overfilled");

  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != '0) |-> (count_q <= Q_CNT_W'(Q_DEPTH - MAX_RES)))
    else $error("burst pushed without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == '0) |=> (count_q == Q_CNT_W'($past(count_q) - 1'b1)))
    else $error("queue count off after pop");

endmodule

### bench/websocket_frame_deframer_tb.sv
// self-checking testbench of websocket_frame_deframer: frames go in byte by byte,
// pong/payload/event words are predicted and compared in order
// depends on wsd_pkg and the websocket_frame_deframer rtl
module websocket_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam logic [2:0]  REG_MAX_PAYLOAD = 3'd0;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned HOLD_AFTER      = 40;
  localparam int unsigned QUIET_LIMIT     = 2000;

  typedef enum logic [2:0] {ST_HDR0, ST_HDR1, ST_EXT, ST_MASK, ST_DATA, ST_STOP} parse_st_e;
  typedef enum logic [1:0] {LEN_IN_HDR, LEN_16BIT, LEN_64BIT} len_enc_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] out_byte
  logic [1:0]  m_axis_tuser;        // [1:0] kind
  logic        m_axis_tlast;

  websocket_frame_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [7:0]  wire_bytes[$];   // bytes still to be sent
  wsd_res_t    due_words[$];    // words the deframer owes us, oldest first
  int unsigned mismatches = 0;
  int unsigned words_seen = 0;
  bit          byte_taken = 1'b0;
  int unsigned send_gap = 0;
  bit          send_calm = 1'b0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          recv_calm = 1'b0;
  int unsigned quiet = 0;

  // parser state of the predictor
  parse_st_e        pstate = ST_HDR0;
  logic [3:0]       cur_opcode = '0;
  logic             cur_masked = 1'b0;
  logic [CFG_W-1:0] frame_len = '0;
  logic             len_overflow = 1'b0;
  logic [3:0]       hdr_left = '0;
  logic [31:0]      mask_word = '0;
  logic [CFG_W-1:0] data_idx = '0;
  logic [CFG_W-1:0] payload_cap = MAX_PAYLOAD_RST;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void put_byte(input logic [7:0] b);
    wire_bytes.insert(wire_bytes.size(), b);
  endfunction

  function automatic void owe_word(input logic [7:0] b, input wsd_kind_e k, input logic l);
    wsd_res_t w;
    w.out_byte = b;
    w.kind     = k;
    w.last     = l;
    due_words.insert(due_words.size(), w);
  endfunction

  // header (and mask key) complete
  function automatic void start_payload();
    if (cur_opcode == OP_PING) begin
      owe_word(PONG_HDR0, KIND_PONG, 1'b0);
      if (frame_len < CFG_W'(LEN_EXT16)) begin
        owe_word(frame_len[7:0], KIND_PONG, frame_len == 0);
      end else begin
        // only the low 16 bits of the length go back
        owe_word({1'b0, LEN_EXT16}, KIND_PONG, 1'b0);
        owe_word(frame_len[15:8], KIND_PONG, 1'b0);
        owe_word(frame_len[7:0], KIND_PONG, 1'b0);
      end
    end
    data_idx = '0;
    pstate = (frame_len == 0) ? ST_HDR0 : ST_DATA;
  endfunction

  function automatic void length_complete();
    if (len_overflow || frame_len > payload_cap) begin
      pstate = ST_STOP;
      owe_word(8'h00, KIND_ERROR, 1'b0);
    end else if (cur_masked) begin
      mask_word = '0;
      hdr_left = 4'd4;
      pstate = ST_MASK;
    end else begin
      start_payload();
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [CFG_W+7:0] widened;
    logic [7:0]       data;
    logic             fin;
    case (pstate)
      ST_HDR0: begin
        cur_opcode = b[3:0];
        pstate = ST_HDR1;
      end
      ST_HDR1: begin
        cur_masked = b[7];
        len_overflow = 1'b0;
        if (cur_opcode == OP_CLOSE) begin
          pstate = ST_STOP;
          owe_word(8'h00, KIND_CLOSE, 1'b0);
        end else if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          frame_len = '0;
          hdr_left = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
          pstate = ST_EXT;
        end else begin
          frame_len = CFG_W'(b[6:0]);
          length_complete();
        end
      end
      ST_EXT: begin
        widened = {frame_len, b};
        // bits shifted out above the length width mark overflow for good
        if (widened[CFG_W+7:CFG_W] != 0) len_overflow = 1'b1;
        frame_len = widened[CFG_W-1:0];
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) length_complete();
      end
      ST_MASK: begin
        mask_word = {mask_word[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) start_payload();
      end
      ST_DATA: begin
        data = b;
        if (cur_masked) data = data ^ 8'(mask_word >> (8 * (3 - int'(data_idx[1:0]))));
        data_idx = data_idx + 1'b1;
        fin = (data_idx == frame_len);
        if (cur_opcode == OP_PING) owe_word(data, KIND_PONG, fin);
        else if (cur_opcode != OP_PONG) owe_word(data, KIND_APP, fin);
        if (fin) pstate = ST_HDR0;
      end
      default: pstate = ST_STOP;
    endcase
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic len_enc_e shortest_enc(input longint unsigned len);
    if (len < 126) return LEN_IN_HDR;
    if (len < 65536) return LEN_16BIT;
    return LEN_64BIT;
  endfunction

  task automatic queue_header(input logic [3:0] flags, input logic [3:0] op,
                              input logic masked, input logic [63:0] len,
                              input len_enc_e enc);
    put_byte({flags, op});
    case (enc)
      LEN_IN_HDR: put_byte({masked, len[6:0]});
      LEN_16BIT: begin
        put_byte({masked, LEN_EXT16});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
      end
      default: begin
        put_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
      end
    endcase
  endtask

  task automatic queue_frame(input logic [3:0] flags, input logic [3:0] op,
                             input logic masked, input int unsigned len,
                             input len_enc_e enc);
    queue_header(flags, op, masked, 64'(len), enc);
    if (masked) repeat (4) put_byte(8'($urandom));
    repeat (len) put_byte(8'($urandom));
  endtask

  // mostly well-formed frames; odd flags, unknown opcodes and padded lengths mixed in
  task automatic queue_random_frames(input int unsigned n_bytes, input int unsigned max_len);
    int unsigned base;
    int unsigned cap;
    int unsigned len;
    logic [3:0]  op;
    len_enc_e    enc;
    base = wire_bytes.size();
    while (wire_bytes.size() - base < n_bytes) begin
      do op = 4'($urandom); while (op == OP_CLOSE);
      cap = ($urandom_range(0, 99) < 85) ? 20 : 300;
      if (cap > max_len) cap = max_len;
      len = $urandom_range(0, cap);
      enc = shortest_enc(len);
      if ($urandom_range(0, 9) == 0) enc = $urandom_range(0, 1) ? LEN_64BIT : LEN_16BIT;
      queue_frame(4'($urandom), op, $urandom_range(0, 9) < 7, len, enc);
    end
  endtask

  task automatic write_max_payload(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_PAYLOAD;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    payload_cap = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (wire_bytes.size() != 0 || s_axis_tvalid || due_words.size() != 0) @(negedge clk_i);
    // a byte that yields nothing may still sit in the pipeline
    repeat (4) @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("mismatch on word %0d: %s got %0h want %0h", words_seen, what, got, want);
  endtask

  // byte acceptance and prediction
  always @(posedge clk_i) begin
    byte_taken = 1'b0;
    if (s_axis_tvalid && s_axis_tready) begin
      deframe_byte(s_axis_tdata);
      void'(wire_bytes.pop_front());
      byte_taken = 1'b1;
    end
  end

  // byte driver
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
    if (s_axis_tvalid && !byte_taken) begin
      // hold the offered byte
    end else if (send_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      send_gap--;
    end else if (wire_bytes.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= wire_bytes[0];
      send_gap = pick_gap(send_calm);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // receiver ready, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (!hold_done && words_seen >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (recv_gap > 0) begin
      m_axis_tready <= 1'b0;
      recv_gap--;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap = pick_gap(recv_calm);
    end
  end

  // word monitor
  always @(posedge clk_i) begin
    wsd_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (due_words.size() == 0) begin
        report_mismatch("word with nothing owed, out_byte", m_axis_tdata, 0);
      end else begin
        want = due_words.pop_front();
        if (m_axis_tdata !== want.out_byte) report_mismatch("out_byte", m_axis_tdata, want.out_byte);
        if (m_axis_tuser !== want.kind) report_mismatch("kind", m_axis_tuser, want.kind);
        if (m_axis_tlast !== want.last) report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned cap;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames at the reset limit
    write_max_payload(MAX_PAYLOAD_RST);
    queue_frame(4'h8, 4'h1, 1'b1, 0, LEN_IN_HDR);
    queue_frame(4'h0, 4'h2, 1'b0, 1, LEN_IN_HDR);
    queue_frame(4'h8, OP_PING, 1'b0, 0, LEN_IN_HDR);
    queue_frame(4'h8, OP_PING, 1'b1, 0, LEN_16BIT);
    queue_frame(4'h8, OP_PONG, 1'b0, 2, LEN_IN_HDR);
    queue_frame(4'h8, OP_PONG, 1'b0, 0, LEN_IN_HDR);
    queue_frame(4'h8, OP_PING, 1'b1, 5, LEN_IN_HDR);
    queue_frame(4'h8, OP_PING, 1'b0, 126, LEN_16BIT);
    queue_frame(4'h7, 4'h2, 1'b0, 2, LEN_64BIT);
    wait_drained();

    // zero limit: only empty frames get through
    write_max_payload('0);
    queue_frame(4'h8, 4'h1, 1'b0, 0, LEN_IN_HDR);
    queue_frame(4'h8, OP_PING, 1'b1, 0, LEN_IN_HDR);
    queue_frame(4'h8, OP_PING, 1'b0, 0, LEN_64BIT);
    wait_drained();

    // random short frames under a random limit
    cap = $urandom_range(8, 300);
    write_max_payload(CFG_W'(cap));
    queue_random_frames(16, 8);
    wait_drained();

    // one terminating event, then bytes that must be ignored
    case ($urandom_range(0, 2))
      0: queue_header(4'($urandom), OP_CLOSE, 1'($urandom), 64'($urandom_range(0, 125)),
                      LEN_IN_HDR);
      1: begin
        cap = $urandom_range(0, 65535);
        write_max_payload(CFG_W'(cap));
        queue_header(4'($urandom), 4'($urandom_range(9, 15)), 1'($urandom), 64'(cap + 1),
                     shortest_enc(cap + 1));
      end
      default: queue_header(4'($urandom), 4'($urandom_range(0, 7)), 1'($urandom),
                            (64'h1 << $urandom_range(17, 63)) | 64'($urandom), LEN_64BIT);
    endcase
    repeat (4) put_byte(8'($urandom));
    wait_drained();
    repeat (10) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
